// ----- design/pdpd_pkg.sv -----
// Package: shared constants and types for the pen digitizer packet decoder
`timescale 1ns / 1ps
package pdpd_pkg;

	localparam int PACKET_BYTES = 7;
	localparam int DATA_BYTES   = PACKET_BYTES - 1;
	localparam int POS_W        = $clog2(PACKET_BYTES);

	localparam int BYTE_W  = 8;
	localparam int DATA_W  = 7;
	localparam int CFG_W   = 12;
	localparam int CFG_IDX_W = 2;
	localparam int RAW_W   = 16;
	localparam int PRESS_W = 10;
	localparam int XPOS_W  = 16;
	localparam int YPOS_W  = 15;

	localparam int HDR_MARK_BIT   = 7;
	localparam int HDR_REJECT_BIT = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 12'd825;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd1200;

	// x range 0x1800 = 3 << 11, y range 0x2000 = 1 << 13
	localparam int PROD_W    = RAW_W + CFG_W;
	localparam int X_SHIFT   = 11;
	localparam int Y_SHIFT   = 13;
	localparam int XQ_W      = PROD_W - X_SHIFT;
	localparam int RECIP_SH  = XQ_W;
	localparam int RECIP_W   = 16;
	localparam logic [RECIP_W-1:0] RECIP_3 = 16'd43691;
	localparam int XM_W      = XQ_W + RECIP_W;

	typedef struct packed {
		logic [RAW_W-1:0]   raw_x;
		logic [RAW_W-1:0]   raw_y;
		logic [PRESS_W-1:0] pressure;
	} pkt_t;

endpackage

// ----- design/pdpd_if.sv -----
// Interfaces: byte channel and sample channel
`timescale 1ns / 1ps
interface pdpd_byte_if;
	import pdpd_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pdpd_sample_if;
	import pdpd_pkg::*;
	logic               valid;
	logic               ready;
	logic [XPOS_W-1:0]  x_pos;
	logic [YPOS_W-1:0]  y_pos;
	logic [PRESS_W-1:0] pen_pressure;
	modport source (output valid, output x_pos, output y_pos, output pen_pressure, input ready);
	modport sink   (input valid, input x_pos, input y_pos, input pen_pressure, output ready);
endinterface

// ----- design/pen_digitizer_packet_decoder.sv -----
// Top level: pen digitizer packet decoder
//
//   channel   dir   beat                             handshake
//   rx        in    rx_byte                          valid / ready
//   sample    out   x_pos, y_pos, pen_pressure       valid / ready
//   cfg       in    cfg_index, cfg_data              cfg_we, no wait
//
// One byte is taken per cycle while rx ready is high; after the last byte of
// its packet a sample passes the framer register, the multiply stage and the
// divide-by-three stage. Reset clears the framer to header hunt and loads the
// default screen size. Each stage holds while the next is full and stalled;
// rx ready drops only when every stage holds a sample.
`timescale 1ns / 1ps
module pen_digitizer_packet_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pdpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pdpd_pkg::CFG_W-1:0]     cfg_data,
	pdpd_byte_if.sink                      rx,
	pdpd_sample_if.source                  sample
);
	import pdpd_pkg::*;

	logic pkt_valid;
	logic pkt_ready;
	pkt_t pkt;

	pdpd_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt)
	);

	pdpd_scaler u_scaler (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt),
		.sample    (sample)
	);

endmodule

// ----- design/pdpd_framer.sv -----
// Framer: hunts for headers, collects data bytes and registers completed packets
`timescale 1ns / 1ps
module pdpd_framer (
	input  logic           clk,
	input  logic           arst_n,
	pdpd_byte_if.sink      rx,
	output logic           pkt_valid,
	input  logic           pkt_ready,
	output pdpd_pkg::pkt_t pkt
);
	import pdpd_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic              reject_q;
	logic [DATA_W-1:0] data_q [DATA_BYTES];
	logic              vld_s1;
	pkt_t              pkt_s1;

	logic              accept;
	logic              is_hdr;
	logic              last;
	logic [DATA_W-1:0] d6;

	assign rx.ready = !vld_s1 || pkt_ready;
	assign accept   = rx.valid && rx.ready;
	assign is_hdr   = rx.rx_byte[HDR_MARK_BIT];
	assign last     = (pos_q == POS_W'(DATA_BYTES));
	assign d6       = rx.rx_byte[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			reject_q <= 1'b0;
		end else if (accept) begin
			if (is_hdr) begin
				pos_q    <= POS_W'(1);
				reject_q <= rx.rx_byte[HDR_REJECT_BIT];
			end else if (pos_q == '0 || pos_q > POS_W'(DATA_BYTES)) begin
				pos_q <= '0;
			end else if (last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_hdr && pos_q != '0 && pos_q <= POS_W'(DATA_BYTES)) begin
			data_q[POS_W'(pos_q - POS_W'(1))] <= d6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= accept && !is_hdr && last && !reject_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_hdr && last) begin
			pkt_s1.raw_x    <= {data_q[0], data_q[1], d6[6:5]};
			pkt_s1.raw_y    <= {data_q[2], data_q[3], d6[4:3]};
			pkt_s1.pressure <= {d6[2:0], data_q[4]};
		end
	end

	assign pkt_valid = vld_s1;
	assign pkt       = pkt_s1;

endmodule

// ----- design/pdpd_scaler.sv -----
// Scaler: screen size registers and the two-stage coordinate scale
`timescale 1ns / 1ps
module pdpd_scaler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pdpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pdpd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           pkt_valid,
	output logic                           pkt_ready,
	input  pdpd_pkg::pkt_t                 pkt,
	pdpd_sample_if.source                  sample
);
	import pdpd_pkg::*;

	logic [CFG_W-1:0]   width_q;
	logic [CFG_W-1:0]   height_q;

	logic               vld_s2;
	logic [PROD_W-1:0]  prod_x_s2;
	logic [YPOS_W-1:0]  y_s2;
	logic [PRESS_W-1:0] press_s2;

	logic               vld_s3;
	logic [XPOS_W-1:0]  x_s3;
	logic [YPOS_W-1:0]  y_s3;
	logic [PRESS_W-1:0] press_s3;

	logic               ready_s2;
	logic [PROD_W-1:0]  prod_y;
	logic [XQ_W-1:0]    xq;
	logic [XM_W-1:0]    xm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SCREEN_WIDTH_RST;
			height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:  width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ready_s2  = !vld_s3 || sample.ready;
	assign pkt_ready = !vld_s2 || ready_s2;

	assign prod_y = PROD_W'(pkt.raw_y) * PROD_W'(height_q);
	assign xq     = prod_x_s2[PROD_W-1:X_SHIFT];
	assign xm     = XM_W'(xq) * XM_W'(RECIP_3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (pkt_ready) begin
				vld_s2 <= pkt_valid;
			end
			if (ready_s2) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_ready && pkt_valid) begin
			prod_x_s2 <= PROD_W'(pkt.raw_x) * PROD_W'(width_q);
			y_s2      <= prod_y[Y_SHIFT +: YPOS_W];
			press_s2  <= pkt.pressure;
		end
		if (ready_s2 && vld_s2) begin
			x_s3     <= xm[RECIP_SH +: XPOS_W];
			y_s3     <= y_s2;
			press_s3 <= press_s2;
		end
	end

	assign sample.valid        = vld_s3;
	assign sample.x_pos        = x_s3;
	assign sample.y_pos        = y_s3;
	assign sample.pen_pressure = press_s3;

endmodule
